// ----- sv/emc_pkg.sv -----
// Shared types, codes and constants of the encoder move controller.
package emc_pkg;

    // Field widths fixed by the interface.
    localparam int CMD_W    = 2;
    localparam int MOTION_W = 2;
    localparam int TGT_W    = 16;
    localparam int DEG_W    = 9;
    localparam int PER_W    = 8;
    localparam int LIMIT_W  = 16;
    localparam int DP_W     = DEG_W + PER_W;
    localparam int TIMER_W  = 17;
    localparam int PINS_W   = 4;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Distance test scale: 360 degrees times 2 for the half-hole rounding.
    localparam int MOVE_SCALE = 720;

    // Command codes carried in the input tuser.
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PULSE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd3;

    // Motion codes of a start beat.
    localparam logic [MOTION_W-1:0] MOT_FWD   = 2'd0;
    localparam logic [MOTION_W-1:0] MOT_BACK  = 2'd1;
    localparam logic [MOTION_W-1:0] MOT_LEFT  = 2'd2;
    localparam logic [MOTION_W-1:0] MOT_RIGHT = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEG   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

    localparam logic [DEG_W-1:0]   DEG_RESET   = 9'd18;
    localparam logic [PER_W-1:0]   PER_RESET   = 8'd20;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd2000;

    // Pin vector order: right_dir, right_speed, left_dir, left_speed (MSB first).
    localparam logic [PINS_W-1:0] PINS_HARD_STOP = 4'b1111;
    localparam logic [PINS_W-1:0] PINS_COAST     = 4'b0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_DECIDE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // input beat accepted this cycle
        logic mul1;      // first product stage
        logic mul2;      // second product stage
        logic finalize;  // apply the outcome and load the result register
        logic end_done;  // the move reached its target
        logic end_fail;  // the move stalled
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic reach;
        logic stall;
    } status_t;

    function automatic logic [PINS_W-1:0] mode_pins(input logic [MOTION_W-1:0] motion);
        logic [PINS_W-1:0] pins;
        unique case (motion)
            MOT_FWD:   pins = 4'b1010;
            MOT_BACK:  pins = 4'b0101;
            MOT_LEFT:  pins = 4'b1001;
            MOT_RIGHT: pins = 4'b0110;
            default:   pins = PINS_COAST;
        endcase
        return pins;
    endfunction

endpackage

// ----- sv/emc_ctrl.sv -----
// Controller state machine of the encoder move controller.
module emc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  emc_pkg::status_t  status,
    output emc_pkg::ctrl_t    ctrl
);

    emc_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            emc_pkg::ST_IDLE:   if (s_tvalid) state_next = emc_pkg::ST_MUL1;
            emc_pkg::ST_MUL1:   state_next = emc_pkg::ST_MUL2;
            emc_pkg::ST_MUL2:   state_next = emc_pkg::ST_DECIDE;
            emc_pkg::ST_DECIDE: if (out_free) state_next = emc_pkg::ST_IDLE;
            default:            state_next = emc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        ctrl          = '0;
        unique case (state_reg)
            emc_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
            end
            emc_pkg::ST_MUL1:   ctrl.mul1 = 1'b1;
            emc_pkg::ST_MUL2:   ctrl.mul2 = 1'b1;
            emc_pkg::ST_DECIDE: begin
                // A reached target wins over a stall on the same beat.
                ctrl.finalize = out_free;
                ctrl.end_done = out_free && status.reach;
                ctrl.end_fail = out_free && status.stall && !status.reach;
            end
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.finalize) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= emc_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- sv/emc_datapath.sv -----
// Datapath of the encoder move controller: move state, products, tests and result register.
module emc_datapath #(
    parameter int COUNT_BITS  = 16,
    parameter int TARGET_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  emc_pkg::ctrl_t                        ctrl,
    input  logic [emc_pkg::CMD_W-1:0]             s_tuser,
    input  logic [emc_pkg::S_DATA_W-1:0]          s_tdata,
    input  logic                                  cfg_we,
    input  logic [emc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [emc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    output emc_pkg::status_t                      status,
    output logic [emc_pkg::M_DATA_W-1:0]          m_tdata
);

    localparam int LHS_W  = TARGET_BITS + 10;
    localparam int MOVE_W = COUNT_BITS + 1 + emc_pkg::DP_W;
    localparam int MCMP_W = (LHS_W > MOVE_W) ? LHS_W : MOVE_W;
    localparam int TURN_W = COUNT_BITS + emc_pkg::DEG_W;
    localparam int TCMP_W = (TURN_W > TARGET_BITS + 1) ? TURN_W : TARGET_BITS + 1;

    logic [emc_pkg::CMD_W-1:0]    command;
    logic [emc_pkg::MOTION_W-1:0] motion;
    logic [emc_pkg::TGT_W-1:0]    target;

    assign command = s_tuser;
    assign motion  = s_tdata[emc_pkg::MOTION_W-1:0];
    assign target  = s_tdata[emc_pkg::MOTION_W +: emc_pkg::TGT_W];

    logic [emc_pkg::DEG_W-1:0]   deg_reg;
    logic [emc_pkg::PER_W-1:0]   per_reg;
    logic [emc_pkg::LIMIT_W-1:0] limit_reg;

    logic                         moving_reg, moving_next;
    logic                         is_turn_reg, is_turn_next;
    logic [TARGET_BITS-1:0]       goal_reg, goal_next;
    logic [COUNT_BITS-1:0]        count_reg, count_next;
    logic [emc_pkg::TIMER_W-1:0]  timer_reg, timer_next;
    logic [emc_pkg::PINS_W-1:0]   pins_reg, pins_next;
    logic                         check_done_reg, check_done_next;
    logic                         check_stall_reg, check_stall_next;

    logic [emc_pkg::DP_W-1:0] dp_reg;
    logic [LHS_W-1:0]         lhs_reg;
    logic [TURN_W-1:0]        turn_prod_reg;
    logic [MOVE_W-1:0]        move_prod_reg;
    logic [emc_pkg::M_DATA_W-1:0] out_reg;

    logic move_hit, turn_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deg_reg   <= emc_pkg::DEG_RESET;
            per_reg   <= emc_pkg::PER_RESET;
            limit_reg <= emc_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                emc_pkg::CFG_DEG:   deg_reg   <= cfg_wdata[emc_pkg::DEG_W-1:0];
                emc_pkg::CFG_PER:   per_reg   <= cfg_wdata[emc_pkg::PER_W-1:0];
                emc_pkg::CFG_LIMIT: limit_reg <= cfg_wdata[emc_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        moving_next      = moving_reg;
        is_turn_next     = is_turn_reg;
        goal_next        = goal_reg;
        count_next       = count_reg;
        timer_next       = timer_reg;
        pins_next        = pins_reg;
        check_done_next  = check_done_reg;
        check_stall_next = check_stall_reg;
        if (ctrl.load) begin
            check_done_next  = 1'b0;
            check_stall_next = 1'b0;
            unique case (command)
                emc_pkg::CMD_TICK: begin
                    if (moving_reg) begin
                        if (timer_reg != '1) begin
                            timer_next = timer_reg + 1'b1;
                        end
                        check_stall_next = 1'b1;
                    end
                end
                emc_pkg::CMD_PULSE: begin
                    if (moving_reg) begin
                        if (count_reg != '1) begin
                            count_next = count_reg + 1'b1;
                        end
                        timer_next      = '0;
                        check_done_next = 1'b1;
                    end
                end
                emc_pkg::CMD_START: begin
                    is_turn_next    = motion[1];
                    goal_next       = TARGET_BITS'(target);
                    count_next      = '0;
                    timer_next      = '0;
                    pins_next       = emc_pkg::mode_pins(motion);
                    moving_next     = 1'b1;
                    check_done_next = 1'b1;
                end
                emc_pkg::CMD_STOP: begin
                    moving_next = 1'b0;
                    pins_next   = emc_pkg::PINS_COAST;
                end
                default: ;
            endcase
        end else if (ctrl.end_done || ctrl.end_fail) begin
            moving_next = 1'b0;
            pins_next   = emc_pkg::PINS_HARD_STOP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            moving_reg      <= 1'b0;
            is_turn_reg     <= 1'b0;
            goal_reg        <= '0;
            count_reg       <= '0;
            timer_reg       <= '0;
            pins_reg        <= emc_pkg::PINS_COAST;
            check_done_reg  <= 1'b0;
            check_stall_reg <= 1'b0;
        end else begin
            moving_reg      <= moving_next;
            is_turn_reg     <= is_turn_next;
            goal_reg        <= goal_next;
            count_reg       <= count_next;
            timer_reg       <= timer_next;
            pins_reg        <= pins_next;
            check_done_reg  <= check_done_next;
            check_stall_reg <= check_stall_next;
        end
    end

    // The distance test needs (2*count+1)*deg*per, so deg*per is formed one stage ahead.
    always_ff @(posedge aclk) begin
        if (ctrl.mul1) begin
            dp_reg        <= emc_pkg::DP_W'(deg_reg) * emc_pkg::DP_W'(per_reg);
            lhs_reg       <= LHS_W'(goal_reg) * LHS_W'(emc_pkg::MOVE_SCALE);
            turn_prod_reg <= TURN_W'(count_reg) * TURN_W'(deg_reg);
        end
        if (ctrl.mul2) begin
            move_prod_reg <= MOVE_W'({count_reg, 1'b1}) * MOVE_W'(dp_reg);
        end
    end

    assign move_hit = MCMP_W'(lhs_reg) <= MCMP_W'(move_prod_reg);
    assign turn_hit = TCMP_W'(turn_prod_reg) >= TCMP_W'({goal_reg, 1'b0});

    assign status.reach = check_done_reg && (is_turn_reg ? turn_hit : move_hit);
    assign status.stall = check_stall_reg &&
                          (timer_reg > emc_pkg::TIMER_W'(limit_reg));

    always_ff @(posedge aclk) begin
        if (ctrl.finalize) begin
            out_reg <= {1'b0, ctrl.end_fail, ctrl.end_done, moving_next,
                        pins_next[0], pins_next[1], pins_next[2], pins_next[3]};
        end
    end

    assign m_tdata = out_reg;

endmodule

// ----- sv/encoder_move_controller.sv -----
// Top level of the encoder move controller.
//
// One input beat per event: s_tuser carries the command (millisecond tick,
// encoder pulse, start move, coast stop); s_tdata carries the motion mode
// and the target of a start. Every accepted beat yields exactly one result
// beat on m_* with the four motor pin levels, the busy flag and the
// finished and failed flags of that event.
// After the edge that accepts the beat, the controller runs two product
// stages for the done test, then a decision cycle that loads the result
// register and sets m_tvalid. A new beat is accepted only in the idle
// state, not while the last one is in its product stages or decision cycle.
// If the receiver stalls, the result waits in the output register; one
// further beat may be accepted, and it holds in its decision cycle until
// the output register is free.
// Reset clears the move, drives all pins low and loads the register
// defaults (18 degrees per hole, 20 cm perimeter, 2000 ms stall limit).
// Configuration writes take effect at once and belong to idle periods.
module encoder_move_controller #(
    parameter int COUNT_BITS  = 16,
    parameter int TARGET_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // command[1:0]
    input  logic [emc_pkg::CMD_W-1:0]          s_tuser,
    // motion[1:0], target[17:2], zero[23:18]
    input  logic [emc_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // right_dir[0], right_speed[1], left_dir[2], left_speed[3],
    // busy_res[4], finished[5], failed[6], zero[7]
    output logic [emc_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                               cfg_we,
    input  logic [emc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [emc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    emc_pkg::ctrl_t   ctrl;
    emc_pkg::status_t status;

    emc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    emc_datapath #(
        .COUNT_BITS  (COUNT_BITS),
        .TARGET_BITS (TARGET_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .status    (status),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- sv/emc_checker.sv -----
// Port-level checker of the encoder move controller, bound to the top level.
module emc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [emc_pkg::M_DATA_W-1:0]   m_tdata
);

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // A held result must not change under the receiver.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // The product stages keep the input closed after an accepted beat.
    a_in_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_acc ##1 !s_acc)
        else $error("input beat accepted during evaluation");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[5] && m_tdata[6]))
        else $error("finished and failed on one beat");

    // An ended move shows a hard stop and is no longer busy.
    a_end_hard_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[5] || m_tdata[6]) |-> m_tdata[4:0] == 5'b01111)
        else $error("ended move without hard stop");

endmodule

bind encoder_move_controller emc_checker u_emc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- test/tb_encoder_move_controller.sv -----
// Self-checking testbench for the encoder move controller.
module tb_encoder_move_controller;

    // Tracks the move state of the controller and holds the pin and flag
    // beats it must produce, oldest first.
    class move_scoreboard;
        logic [emc_pkg::DEG_W-1:0]   deg_per_hole;
        logic [emc_pkg::PER_W-1:0]   perimeter;
        logic [emc_pkg::LIMIT_W-1:0] stall_limit;

        bit                          moving;
        bit                          turning;
        logic [emc_pkg::TGT_W-1:0]   goal;
        logic [15:0]                 pulses;
        logic [emc_pkg::TIMER_W-1:0] idle_ms;
        logic [emc_pkg::PINS_W-1:0]  pins;

        logic [emc_pkg::M_DATA_W-1:0] pin_beats[$];
        string                        field_name[emc_pkg::M_DATA_W];
        int                           errors;

        function new();
            deg_per_hole = emc_pkg::DEG_RESET;
            perimeter    = emc_pkg::PER_RESET;
            stall_limit  = emc_pkg::LIMIT_RESET;
            moving       = 1'b0;
            turning      = 1'b0;
            goal         = '0;
            pulses       = '0;
            idle_ms      = '0;
            pins         = emc_pkg::PINS_COAST;
            errors       = 0;
            field_name   = '{"right_dir", "right_speed", "left_dir", "left_speed",
                             "busy", "finished", "failed", "pad"};
        endfunction

        // A turn counts whole holes against twice the angle; a straight move
        // rounds to the nearest half hole, scaled to stay in integers.
        function bit goal_met();
            longint unsigned c;
            longint unsigned d;
            longint unsigned p;
            longint unsigned t;
            c = 64'(pulses);
            d = 64'(deg_per_hole);
            p = 64'(perimeter);
            t = 64'(goal);
            if (turning)
                return c * d >= 64'd2 * t;
            return 64'(emc_pkg::MOVE_SCALE) * t <= (64'd2 * c + 64'd1) * d * p;
        endfunction

        function void note_input(logic [emc_pkg::CMD_W-1:0] cmd,
                                 logic [emc_pkg::MOTION_W-1:0] mot,
                                 logic [emc_pkg::TGT_W-1:0] tgt);
            bit done;
            bit fail;
            done = 1'b0;
            fail = 1'b0;
            case (cmd)
                emc_pkg::CMD_TICK: begin
                    if (moving) begin
                        if (idle_ms != '1)
                            idle_ms = idle_ms + 1'b1;
                        if (idle_ms > emc_pkg::TIMER_W'(stall_limit)) begin
                            moving = 1'b0;
                            fail   = 1'b1;
                            pins   = emc_pkg::PINS_HARD_STOP;
                        end
                    end
                end
                emc_pkg::CMD_PULSE: begin
                    if (moving) begin
                        if (pulses != '1)
                            pulses = pulses + 1'b1;
                        idle_ms = '0;
                        if (goal_met()) begin
                            moving = 1'b0;
                            done   = 1'b1;
                            pins   = emc_pkg::PINS_HARD_STOP;
                        end
                    end
                end
                emc_pkg::CMD_START: begin
                    turning = (mot == emc_pkg::MOT_LEFT) || (mot == emc_pkg::MOT_RIGHT);
                    goal    = tgt;
                    pulses  = '0;
                    idle_ms = '0;
                    moving  = 1'b1;
                    case (mot)
                        emc_pkg::MOT_FWD:  pins = 4'b1010;
                        emc_pkg::MOT_BACK: pins = 4'b0101;
                        emc_pkg::MOT_LEFT: pins = 4'b1001;
                        default:           pins = 4'b0110;
                    endcase
                    if (goal_met()) begin
                        moving = 1'b0;
                        done   = 1'b1;
                        pins   = emc_pkg::PINS_HARD_STOP;
                    end
                end
                default: begin
                    moving = 1'b0;
                    pins   = emc_pkg::PINS_COAST;
                end
            endcase
            // The pin vector runs right_dir down to left_speed; the beat has
            // right_dir in its lowest bit.
            pin_beats.push_back({1'b0, fail, done, moving,
                                 pins[0], pins[1], pins[2], pins[3]});
        endfunction

        function void check_result(logic [emc_pkg::M_DATA_W-1:0] got);
            logic [emc_pkg::M_DATA_W-1:0] want;
            if (pin_beats.size() == 0) begin
                errors++;
                if (errors < 50)
                    $display("%0t: result beat %h arrived with nothing expected", $time, got);
                return;
            end
            want = pin_beats.pop_front();
            for (int i = 0; i < emc_pkg::M_DATA_W; i++) begin
                if (got[i] !== want[i]) begin
                    errors++;
                    if (errors < 50)
                        $display("%0t: %s expected %b actual %b", $time, field_name[i],
                                 want[i], got[i]);
                end
            end
        endfunction

        function int pending();
            return pin_beats.size();
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [emc_pkg::CMD_W-1:0]      s_tuser;
    logic [emc_pkg::S_DATA_W-1:0]   s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [emc_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           cfg_we;
    logic [emc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [emc_pkg::CFG_DATA_W-1:0] cfg_wdata;

    bit idling;
    move_scoreboard sb = new();

    encoder_move_controller u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random bursts of back-pressure while idling is on.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (idling && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Called at a falling edge; returns at the falling edge after the beat
    // is taken, with tvalid still high.
    task automatic send_event(input logic [emc_pkg::CMD_W-1:0] cmd,
                              input logic [emc_pkg::MOTION_W-1:0] mot,
                              input logic [emc_pkg::TGT_W-1:0] tgt);
        if (idling && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {{(emc_pkg::S_DATA_W - emc_pkg::TGT_W - emc_pkg::MOTION_W){1'b0}},
                    tgt, mot};
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_input(cmd, mot, tgt);
        @(negedge aclk);
    endtask

    // Waits until every result is back, then loads all three registers.
    task automatic set_registers(input logic [emc_pkg::DEG_W-1:0] deg,
                                 input logic [emc_pkg::PER_W-1:0] per,
                                 input logic [emc_pkg::LIMIT_W-1:0] limit);
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (8) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = emc_pkg::CFG_DEG;
        cfg_wdata = emc_pkg::CFG_DATA_W'(deg);
        @(negedge aclk);
        cfg_index = emc_pkg::CFG_PER;
        cfg_wdata = emc_pkg::CFG_DATA_W'(per);
        @(negedge aclk);
        cfg_index = emc_pkg::CFG_LIMIT;
        cfg_wdata = limit;
        @(negedge aclk);
        cfg_we = 1'b0;
        sb.deg_per_hole = deg;
        sb.perimeter    = per;
        sb.stall_limit  = limit;
    endtask

    // Mostly whole moves: a start, then a run of pulses, ticks and rare stops
    // whose mix varies per move, with stray beats of any kind in between.
    task automatic run_moves(input int count);
        int                           sent;
        int                           len;
        int                           pulse_pct;
        int                           r;
        logic [emc_pkg::CMD_W-1:0]    cmd;
        logic [emc_pkg::MOTION_W-1:0] mot;
        logic [emc_pkg::TGT_W-1:0]    tgt;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                cmd = emc_pkg::CMD_W'($urandom_range(0, 3));
                mot = emc_pkg::MOTION_W'($urandom_range(0, 3));
                tgt = emc_pkg::TGT_W'($urandom);
                send_event(cmd, mot, tgt);
                sent++;
            end else begin
                mot = emc_pkg::MOTION_W'($urandom_range(0, 3));
                r = $urandom_range(0, 9);
                if (r < 4)
                    tgt = emc_pkg::TGT_W'($urandom_range(0, 8));
                else if (r < 8)
                    tgt = emc_pkg::TGT_W'($urandom_range(0, 60));
                else if (r < 9)
                    tgt = emc_pkg::TGT_W'($urandom_range(0, 1000));
                else
                    tgt = emc_pkg::TGT_W'($urandom);
                send_event(emc_pkg::CMD_START, mot, tgt);
                sent++;
                pulse_pct = $urandom_range(10, 95);
                len = $urandom_range(1, 40);
                repeat (len) begin
                    r = $urandom_range(0, 99);
                    if (r < 2)
                        cmd = emc_pkg::CMD_STOP;
                    else if (r < pulse_pct)
                        cmd = emc_pkg::CMD_PULSE;
                    else
                        cmd = emc_pkg::CMD_TICK;
                    mot = emc_pkg::MOTION_W'($urandom_range(0, 3));
                    tgt = emc_pkg::TGT_W'($urandom);
                    send_event(cmd, mot, tgt);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        idling    = 1'b1;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = emc_pkg::CMD_TICK;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = emc_pkg::CFG_DEG;
        cfg_wdata = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Short stall limit so that a stall shows within a few ticks.
        set_registers(emc_pkg::DEG_RESET, emc_pkg::PER_RESET, 16'd2);
        send_event(emc_pkg::CMD_TICK, emc_pkg::MOT_FWD, 16'd0);
        send_event(emc_pkg::CMD_PULSE, emc_pkg::MOT_BACK, 16'hFFFF);
        send_event(emc_pkg::CMD_STOP, emc_pkg::MOT_LEFT, 16'd0);
        send_event(emc_pkg::CMD_START, emc_pkg::MOT_FWD, 16'd0);
        send_event(emc_pkg::CMD_START, emc_pkg::MOT_BACK, 16'hFFFF);
        send_event(emc_pkg::CMD_PULSE, emc_pkg::MOT_FWD, 16'd0);
        send_event(emc_pkg::CMD_TICK, emc_pkg::MOT_FWD, 16'd0);
        send_event(emc_pkg::CMD_TICK, emc_pkg::MOT_FWD, 16'd0);
        send_event(emc_pkg::CMD_TICK, emc_pkg::MOT_FWD, 16'd0);
        send_event(emc_pkg::CMD_START, emc_pkg::MOT_LEFT, 16'd0);
        send_event(emc_pkg::CMD_START, emc_pkg::MOT_RIGHT, 16'd18);
        send_event(emc_pkg::CMD_PULSE, emc_pkg::MOT_FWD, 16'd0);
        send_event(emc_pkg::CMD_START, emc_pkg::MOT_FWD, 16'd10);
        send_event(emc_pkg::CMD_PULSE, emc_pkg::MOT_FWD, 16'd0);
        send_event(emc_pkg::CMD_STOP, emc_pkg::MOT_RIGHT, 16'hFFFF);
        send_event(emc_pkg::CMD_START, emc_pkg::MOT_RIGHT, 16'd18);
        send_event(emc_pkg::CMD_PULSE, emc_pkg::MOT_FWD, 16'd0);
        send_event(emc_pkg::CMD_PULSE, emc_pkg::MOT_FWD, 16'd0);
        send_event(emc_pkg::CMD_START, emc_pkg::MOT_FWD, 16'd1);
        send_event(emc_pkg::CMD_PULSE, emc_pkg::MOT_FWD, 16'd0);
        send_event(emc_pkg::CMD_START, emc_pkg::MOT_LEFT, 16'hFFFF);
        send_event(emc_pkg::CMD_TICK, emc_pkg::MOT_FWD, 16'd0);
        send_event(emc_pkg::CMD_PULSE, emc_pkg::MOT_FWD, 16'd0);
        send_event(emc_pkg::CMD_TICK, emc_pkg::MOT_FWD, 16'd0);
        send_event(emc_pkg::CMD_STOP, emc_pkg::MOT_FWD, 16'd0);

        set_registers(emc_pkg::DEG_RESET, emc_pkg::PER_RESET, emc_pkg::LIMIT_RESET);
        run_moves(250);
        set_registers(9'd1, 8'd1, 16'd1);
        run_moves(250);
        set_registers(9'd360, 8'd255, 16'hFFFF);
        run_moves(250);
        // Zero step angle and perimeter: only a zero target can be reached.
        set_registers(9'd0, 8'd0, 16'd0);
        run_moves(150);
        set_registers(9'd511, 8'd255, 16'd3);
        run_moves(250);
        idling = 1'b0;
        set_registers(9'd45, 8'd31, 16'd7);
        run_moves(250);

        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
